// ===== sv/swhsr_pkg.sv =====
// ----------------------------------------------------------------------------
// swhsr_pkg: shared types and constants
// Item and result layouts, configuration register indexes and reset values
// for the single-wire humidity sensor reader.
// ----------------------------------------------------------------------------
package swhsr_pkg;

    // Timer and register widths
    localparam int TimerBits  = 16;
    localparam int CfgBits    = 16;
    localparam int CfgRegs    = 4;
    localparam int CfgIdxBits = $clog2(CfgRegs);
    localparam int FrameBits  = 40;
    localparam int CountBits  = 6;

    // Stream payload widths, padded to whole bytes
    localparam int InBits  = 3 + TimerBits;
    localparam int InBytes = (InBits + 7) / 8;
    localparam int OutBits  = 1 + 2 + 1 + 8 + 8;
    localparam int OutBytes = (OutBits + 7) / 8;

    // Configuration register indexes
    localparam logic [CfgIdxBits-1:0] RegStartLow     = CfgIdxBits'(0);
    localparam logic [CfgIdxBits-1:0] RegRespTimeout  = CfgIdxBits'(1);
    localparam logic [CfgIdxBits-1:0] RegBitLowTimeout = CfgIdxBits'(2);
    localparam logic [CfgIdxBits-1:0] RegOneThreshold = CfgIdxBits'(3);

    // Configuration reset values
    localparam logic [CfgBits-1:0] RstStartLow      = CfgBits'(19000);
    localparam logic [CfgBits-1:0] RstRespTimeout   = CfgBits'(100);
    localparam logic [CfgBits-1:0] RstBitLowTimeout = CfgBits'(80);
    localparam logic [CfgBits-1:0] RstOneThreshold  = CfgBits'(45);

    // Status codes
    localparam logic [1:0] StIdle  = 2'd0;
    localparam logic [1:0] StBusy  = 2'd1;
    localparam logic [1:0] StOk    = 2'd2;
    localparam logic [1:0] StError = 2'd3;

    typedef struct packed {
        logic [CfgBits-1:0] start_low_time;
        logic [CfgBits-1:0] response_timeout;
        logic [CfgBits-1:0] bit_low_timeout;
        logic [CfgBits-1:0] one_threshold;
    } t_cfg;

    typedef struct packed {
        logic [TimerBits-1:0] time_us;
        logic                 line_level;
        logic                 take_data;
        logic                 start_request;
    } t_item;

    typedef struct packed {
        logic [7:0] temperature;
        logic [7:0] humidity;
        logic       data_ready;
        logic [1:0] status;
        logic       drive_low;
    } t_result;

endpackage

// ===== sv/swhsr_core.sv =====
// ----------------------------------------------------------------------------
// swhsr_core: protocol state machine
// Holds the reader state and applies one poll per enabled cycle: start
// request, one protocol step, then take-data. The result reflects the state
// after the whole poll.
// ----------------------------------------------------------------------------
module swhsr_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  swhsr_pkg::t_cfg    i_cfg,
    input  swhsr_pkg::t_item   i_item,
    output swhsr_pkg::t_result o_result
);

    // Phase codes
    localparam logic [3:0] PhIdle     = 4'd0;
    localparam logic [3:0] PhPullLow  = 4'd1;
    localparam logic [3:0] PhHoldLow  = 4'd2;
    localparam logic [3:0] PhRespLow  = 4'd3;
    localparam logic [3:0] PhRespHigh = 4'd4;
    localparam logic [3:0] PhLeadLow  = 4'd5;
    localparam logic [3:0] PhBitLow   = 4'd6;
    localparam logic [3:0] PhBitHigh  = 4'd7;
    localparam logic [3:0] PhCheck    = 4'd8;

    logic [3:0]                         r_phase,     n_phase;
    logic [swhsr_pkg::TimerBits-1:0]    r_last_time, n_last_time;
    logic [swhsr_pkg::FrameBits-1:0]    r_frame,     n_frame;
    logic [swhsr_pkg::CountBits-1:0]    r_bit_cnt,   n_bit_cnt;
    logic [7:0]                         r_humidity,  n_humidity;
    logic [7:0]                         r_temp,      n_temp;
    logic                               r_ready,     n_ready;
    logic [1:0]                         r_status,    n_status;
    logic                               r_drive,     n_drive;

    logic [swhsr_pkg::TimerBits-1:0] elapsed;
    logic [7:0]                      sum;
    logic                            bit_val;

    // Elapsed time wraps modulo the timer width
    assign elapsed = i_item.time_us - r_last_time;
    assign sum     = r_frame[39:32] + r_frame[31:24] + r_frame[23:16] + r_frame[15:8];
    assign bit_val = (elapsed > i_cfg.one_threshold);

    // Start, step, take for one poll
    always_comb begin
        n_phase     = r_phase;
        n_last_time = r_last_time;
        n_frame     = r_frame;
        n_bit_cnt   = r_bit_cnt;
        n_humidity  = r_humidity;
        n_temp      = r_temp;
        n_ready     = r_ready;
        n_status    = r_status;
        n_drive     = r_drive;

        if (i_item.start_request && (r_phase == PhIdle)) begin
            n_phase  = PhPullLow;
            n_status = swhsr_pkg::StBusy;
            n_ready  = 1'b0;
        end

        case (n_phase)
            PhIdle: begin
            end
            PhPullLow: begin
                n_drive     = 1'b1;
                n_last_time = i_item.time_us;
                n_phase     = PhHoldLow;
            end
            PhHoldLow: begin
                if (elapsed >= i_cfg.start_low_time) begin
                    n_drive     = 1'b0;
                    n_last_time = i_item.time_us;
                    n_phase     = PhRespLow;
                end
            end
            PhRespLow: begin
                if (!i_item.line_level) begin
                    n_last_time = i_item.time_us;
                    n_phase     = PhRespHigh;
                end else if (elapsed > i_cfg.response_timeout) begin
                    n_status = swhsr_pkg::StError;
                    n_phase  = PhIdle;
                    n_drive  = 1'b0;
                end
            end
            PhRespHigh: begin
                if (i_item.line_level) begin
                    n_last_time = i_item.time_us;
                    n_phase     = PhLeadLow;
                end else if (elapsed > i_cfg.response_timeout) begin
                    n_status = swhsr_pkg::StError;
                    n_phase  = PhIdle;
                    n_drive  = 1'b0;
                end
            end
            PhLeadLow: begin
                if (!i_item.line_level) begin
                    n_last_time = i_item.time_us;
                    n_phase     = PhBitLow;
                    n_bit_cnt   = '0;
                    n_frame     = '0;
                end else if (elapsed > i_cfg.response_timeout) begin
                    n_status = swhsr_pkg::StError;
                    n_phase  = PhIdle;
                    n_drive  = 1'b0;
                end
            end
            PhBitLow: begin
                if (i_item.line_level) begin
                    n_last_time = i_item.time_us;
                    n_phase     = PhBitHigh;
                end else if (elapsed > i_cfg.bit_low_timeout) begin
                    n_status = swhsr_pkg::StError;
                    n_phase  = PhIdle;
                    n_drive  = 1'b0;
                end
            end
            PhBitHigh: begin
                if (!i_item.line_level) begin
                    // Shift in the decoded bit, most significant first
                    n_frame     = {r_frame[swhsr_pkg::FrameBits-2:0], bit_val};
                    n_bit_cnt   = r_bit_cnt + swhsr_pkg::CountBits'(1);
                    n_last_time = i_item.time_us;
                    n_phase     = (n_bit_cnt >= swhsr_pkg::CountBits'(swhsr_pkg::FrameBits))
                                  ? PhCheck : PhBitLow;
                end else if (elapsed > i_cfg.response_timeout) begin
                    n_status = swhsr_pkg::StError;
                    n_phase  = PhIdle;
                    n_drive  = 1'b0;
                end
            end
            PhCheck: begin
                // Accept the frame only when the checksum byte matches
                if (r_frame[7:0] == sum) begin
                    n_humidity = r_frame[39:32];
                    n_temp     = r_frame[23:16];
                    n_ready    = 1'b1;
                    n_status   = swhsr_pkg::StOk;
                end else begin
                    n_status = swhsr_pkg::StError;
                end
                n_phase = PhIdle;
                n_drive = 1'b0;
            end
            default: begin
                n_phase = PhIdle;
            end
        endcase

        if (i_item.take_data) begin
            n_ready = 1'b0;
        end
    end

    // Advance state on each processed poll
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PhIdle;
            r_last_time <= '0;
            r_frame     <= '0;
            r_bit_cnt   <= '0;
            r_humidity  <= '0;
            r_temp      <= '0;
            r_ready     <= 1'b0;
            r_status    <= swhsr_pkg::StIdle;
            r_drive     <= 1'b0;
        end else if (i_en) begin
            r_phase     <= n_phase;
            r_last_time <= n_last_time;
            r_frame     <= n_frame;
            r_bit_cnt   <= n_bit_cnt;
            r_humidity  <= n_humidity;
            r_temp      <= n_temp;
            r_ready     <= n_ready;
            r_status    <= n_status;
            r_drive     <= n_drive;
        end
    end

    assign o_result.drive_low   = n_drive;
    assign o_result.status      = n_status;
    assign o_result.data_ready  = n_ready;
    assign o_result.humidity    = n_humidity;
    assign o_result.temperature = n_temp;

endmodule

// ===== sv/single_wire_humidity_sensor_reader.sv =====
// ----------------------------------------------------------------------------
// single_wire_humidity_sensor_reader: polled single-wire sensor reader
// Each input item is one poll of the sensor line with a microsecond time
// stamp; each poll yields one result item with line drive, status, the
// data-ready flag and the last good humidity and temperature bytes.
// ----------------------------------------------------------------------------
// Rate: one poll item per clock cycle while the output is not stalled. An item
// is caught in the input register when it is accepted; it is then applied to
// the protocol state and its result is loaded into the output register at the
// same edge, once that register is free or draining. A stalled output holds the
// result and back-pressures the input. The state update of one poll is
// combinational logic between the state registers, which is what sets the rate.
// Configuration writes are taken any cycle and should be made while no polls
// are in flight.
module single_wire_humidity_sensor_reader (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write port
    input  logic                                i_cfg_we,
    input  logic [swhsr_pkg::CfgIdxBits-1:0]    i_cfg_addr,
    input  logic [swhsr_pkg::CfgBits-1:0]       i_cfg_wdata,
    // Poll items
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [0] start_request, [1] take_data, [2] line_level, [18:3] time_us
    input  logic [swhsr_pkg::InBytes*8-1:0]     s_axis_tdata,
    // Result items
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] drive_low, [2:1] status, [3] data_ready, [11:4] humidity,
    // [19:12] temperature
    output logic [swhsr_pkg::OutBytes*8-1:0]    m_axis_tdata
);

    swhsr_pkg::t_cfg    r_cfg;
    swhsr_pkg::t_item   r_item;
    logic               r_in_vld;
    swhsr_pkg::t_result r_out;
    logic               r_out_vld;
    swhsr_pkg::t_result step_result;
    logic               advance;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_low_time   <= swhsr_pkg::RstStartLow;
            r_cfg.response_timeout <= swhsr_pkg::RstRespTimeout;
            r_cfg.bit_low_timeout  <= swhsr_pkg::RstBitLowTimeout;
            r_cfg.one_threshold    <= swhsr_pkg::RstOneThreshold;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                swhsr_pkg::RegStartLow:      r_cfg.start_low_time   <= i_cfg_wdata;
                swhsr_pkg::RegRespTimeout:   r_cfg.response_timeout <= i_cfg_wdata;
                swhsr_pkg::RegBitLowTimeout: r_cfg.bit_low_timeout  <= i_cfg_wdata;
                swhsr_pkg::RegOneThreshold:  r_cfg.one_threshold    <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Move an item forward when the result register is free or draining
    assign advance       = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_item <= s_axis_tdata[swhsr_pkg::InBits-1:0];
        end
    end

    swhsr_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_cfg    (r_cfg),
        .i_item   (r_item),
        .o_result (step_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= step_result;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {{(swhsr_pkg::OutBytes*8 - swhsr_pkg::OutBits){1'b0}}, r_out};

endmodule
